// ===== rtl/core/ogss_pkg.sv =====
// ----------------------------------------------------------------------------
// ogss_pkg
// Shared constants, command codes and request types for the grid store core.
// ----------------------------------------------------------------------------
package ogss_pkg;

    localparam int GRID_HALF_SPAN_DEF = 63;
    localparam int GRID_SIDE_DEF      = 127;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 12;
    localparam int DATA_W  = 16;

    localparam logic [DATA_W-1:0] SAT_CEIL_RST = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET    = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_GET    = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] data;
        logic              in_rng;
    } t_req_meta;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

// ===== rtl/core/occupancy_grid_saturating_store_core.sv =====
// Throughput: one request per cycle while results are taken, set by the
// one-read one-write cell memory read-modify-write with one-deep forwarding
// of the previous write. Reset: the saturation ceiling returns to 65535;
// the store is then swept to zero, one cell a cycle, across the
// GRID_SIDE*GRID_SIDE cells (16129 by default) with request ready held low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// occupancy_grid_saturating_store_core
// Occupancy grid cell store with set, saturating change and get requests.
// ----------------------------------------------------------------------------
module occupancy_grid_saturating_store_core #(
    parameter int GRID_HALF_SPAN = ogss_pkg::GRID_HALF_SPAN_DEF,
    parameter int GRID_SIDE      = ogss_pkg::GRID_SIDE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ogss_pkg::DATA_W-1:0]          i_cfg_wdata,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  logic [ogss_pkg::CMD_W-1:0]           i_req_cmd,
    input  logic signed [ogss_pkg::COORD_W-1:0]  i_req_coord_x,
    input  logic signed [ogss_pkg::COORD_W-1:0]  i_req_coord_y,
    input  logic [ogss_pkg::DATA_W-1:0]          i_req_data,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output logic [ogss_pkg::DATA_W-1:0]          o_res_cell_value,
    output logic                                 o_res_in_range
);

    localparam int ADDR_W = $clog2(GRID_SIDE * GRID_SIDE);

    logic [ogss_pkg::DATA_W-1:0] r_sat_ceiling;
    logic                        en, busy, a_vld;
    ogss_pkg::t_req_meta         a_meta;
    logic [ADDR_W-1:0]           a_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_ceiling <= ogss_pkg::SAT_CEIL_RST;
        end else if (i_cfg_we) begin
            r_sat_ceiling <= i_cfg_wdata;
        end
    end

    assign o_req_ready = en && !busy;

    ogss_addr #(
        .GRID_HALF_SPAN (GRID_HALF_SPAN),
        .GRID_SIDE      (GRID_SIDE)
    ) u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_req_valid && o_req_ready),
        .i_cmd     (i_req_cmd),
        .i_coord_x (i_req_coord_x),
        .i_coord_y (i_req_coord_y),
        .i_data    (i_req_data),
        .o_vld     (a_vld),
        .o_meta    (a_meta),
        .o_addr    (a_addr)
    );

    ogss_rmw #(
        .GRID_SIDE (GRID_SIDE)
    ) u_rmw (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (a_vld),
        .i_meta           (a_meta),
        .i_addr           (a_addr),
        .i_sat_ceiling    (r_sat_ceiling),
        .o_en             (en),
        .o_busy           (busy),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_res_cell_value (o_res_cell_value),
        .o_res_in_range   (o_res_in_range)
    );

endmodule

// ===== rtl/core/ogss_addr.sv =====
// ----------------------------------------------------------------------------
// ogss_addr
// Range check and cell address pipeline: offset, row multiply, and reduction
// modulo the store depth by reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module ogss_addr #(
    parameter int GRID_HALF_SPAN = ogss_pkg::GRID_HALF_SPAN_DEF,
    parameter int GRID_SIDE      = ogss_pkg::GRID_SIDE_DEF,
    localparam int ADDR_W        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic [ogss_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [ogss_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [ogss_pkg::COORD_W-1:0]  i_coord_y,
    input  logic [ogss_pkg::DATA_W-1:0]          i_data,
    output logic                                 o_vld,
    output ogss_pkg::t_req_meta                  o_meta,
    output logic [ADDR_W-1:0]                    o_addr
);

    localparam int DEPTH    = GRID_SIDE * GRID_SIDE;
    localparam int SPAN_W   = $clog2(2 * GRID_HALF_SPAN + 1);
    localparam int FULL_MAX = 2 * GRID_HALF_SPAN * GRID_SIDE + 2 * GRID_HALF_SPAN;
    localparam int FULL_W   = $clog2(FULL_MAX + 1);
    localparam int SH       = (FULL_W > ADDR_W) ? FULL_W : ADDR_W;
    localparam longint RECIP = (longint'(1) << SH) / DEPTH;
    localparam int Q_W      = $clog2(FULL_MAX / DEPTH + 2);
    localparam int PROD_W   = SH + Q_W;
    localparam int CW       = ogss_pkg::COORD_W + 1;
    localparam logic signed [CW-1:0] HALF_S = CW'(GRID_HALF_SPAN);

    logic [4:0]          r_vld;
    ogss_pkg::t_req_meta r_s1_meta, r_s2_meta, r_s3_meta, r_s4_meta, r_s5_meta;
    logic [SPAN_W-1:0]   r_s1_a, r_s1_b;
    logic [FULL_W-1:0]   r_s2_full, r_s3_full, r_s4_full, r_s4_qd;
    logic [Q_W-1:0]      r_s3_q;
    logic [ADDR_W-1:0]   r_s5_addr;

    logic signed [CW-1:0] x_ext, y_ext, a_sum, b_sum;
    logic                 in_rng;
    ogss_pkg::t_req_meta  n_s1_meta;
    logic [FULL_W-1:0]    full_c, qd_c, rem_c;
    logic [PROD_W-1:0]    prod_c;
    logic [ADDR_W-1:0]    addr_c;

    always_comb begin
        x_ext  = {i_coord_x[ogss_pkg::COORD_W-1], i_coord_x};
        y_ext  = {i_coord_y[ogss_pkg::COORD_W-1], i_coord_y};
        in_rng = (x_ext >= -HALF_S) && (x_ext <= HALF_S)
              && (y_ext >= -HALF_S) && (y_ext <= HALF_S);
        a_sum  = x_ext + HALF_S;
        b_sum  = HALF_S - y_ext;
        n_s1_meta.cmd    = ogss_pkg::t_cmd'(i_cmd);
        n_s1_meta.data   = i_data;
        n_s1_meta.in_rng = in_rng;
    end

    always_comb begin
        full_c = FULL_W'(r_s1_a) * FULL_W'(GRID_SIDE) + FULL_W'(r_s1_b);
        prod_c = PROD_W'(r_s2_full) * PROD_W'(RECIP);
        qd_c   = FULL_W'(r_s3_q) * FULL_W'(DEPTH);
        rem_c  = r_s4_full - r_s4_qd;
        if (32'(rem_c) >= 32'(DEPTH)) begin
            addr_c = ADDR_W'(rem_c - FULL_W'(DEPTH));
        end else begin
            addr_c = ADDR_W'(rem_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_meta <= n_s1_meta;
            r_s1_a    <= a_sum[SPAN_W-1:0];
            r_s1_b    <= b_sum[SPAN_W-1:0];
            r_s2_meta <= r_s1_meta;
            r_s2_full <= full_c;
            r_s3_meta <= r_s2_meta;
            r_s3_full <= r_s2_full;
            r_s3_q    <= prod_c[SH +: Q_W];
            r_s4_meta <= r_s3_meta;
            r_s4_full <= r_s3_full;
            r_s4_qd   <= qd_c;
            r_s5_meta <= r_s4_meta;
            r_s5_addr <= addr_c;
        end
    end

    assign o_vld  = r_vld[4];
    assign o_meta = r_s5_meta;
    assign o_addr = r_s5_addr;

endmodule

// ===== rtl/core/ogss_rmw.sv =====
// ----------------------------------------------------------------------------
// ogss_rmw
// Cell store with read-modify-write, one-deep write forwarding, saturating
// change, result register and the post-reset clearing sweep.
// ----------------------------------------------------------------------------
module ogss_rmw #(
    parameter int GRID_SIDE = ogss_pkg::GRID_SIDE_DEF,
    localparam int ADDR_W   = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  ogss_pkg::t_req_meta          i_meta,
    input  logic [ADDR_W-1:0]            i_addr,
    input  logic [ogss_pkg::DATA_W-1:0]  i_sat_ceiling,
    output logic                         o_en,
    output logic                         o_busy,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [ogss_pkg::DATA_W-1:0]  o_res_cell_value,
    output logic                         o_res_in_range
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int DW    = ogss_pkg::DATA_W;

    logic [DW-1:0] mem [DEPTH];

    ogss_pkg::t_state    r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_m_vld, r_fwd_vld, r_res_valid, r_res_in_range;
    ogss_pkg::t_req_meta r_m_meta;
    logic [ADDR_W-1:0]   r_m_addr, r_fwd_addr;
    logic [DW-1:0]       r_rdata, r_fwd_val, r_res_value;

    logic                en, busy, clr_last, fwd_hit, pos, w_we;
    logic [DW-1:0]       cur, sum, newv, w_data;
    logic [ADDR_W-1:0]   w_addr;

    assign clr_last   = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign n_clr_addr = r_clr_addr + ADDR_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ogss_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ogss_pkg::ST_RUN;
                end
            end
            ogss_pkg::ST_RUN: begin
                n_state = ogss_pkg::ST_RUN;
            end
            default: begin
                n_state = ogss_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ogss_pkg::ST_CLEAR: busy = 1'b1;
            ogss_pkg::ST_RUN:   busy = 1'b0;
            default:            busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ogss_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (busy) begin
                r_clr_addr <= n_clr_addr;
            end
        end
    end

    assign en = !r_res_valid || i_res_ready;

    always_comb begin
        fwd_hit = r_fwd_vld && (r_fwd_addr == r_m_addr);
        cur     = fwd_hit ? r_fwd_val : r_rdata;
        sum     = cur + r_m_meta.data;
        pos     = (r_m_meta.data != '0) && !r_m_meta.data[DW-1];
        case (r_m_meta.cmd)
            ogss_pkg::CMD_SET: begin
                newv = r_m_meta.data;
            end
            ogss_pkg::CMD_CHANGE: begin
                if (pos) begin
                    newv = (cur > sum) ? i_sat_ceiling : sum;
                end else begin
                    newv = (cur < sum) ? '0 : sum;
                end
            end
            default: begin
                newv = cur;
            end
        endcase
    end

    always_comb begin
        w_we   = busy || (en && r_m_vld && r_m_meta.in_rng);
        w_addr = busy ? r_clr_addr : r_m_addr;
        w_data = busy ? '0 : newv;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
        if (en) begin
            r_rdata <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld     <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (en) begin
            r_m_vld     <= i_vld;
            r_fwd_vld   <= r_m_vld && r_m_meta.in_rng;
            r_res_valid <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_meta       <= i_meta;
            r_m_addr       <= i_addr;
            r_fwd_addr     <= r_m_addr;
            r_fwd_val      <= newv;
            r_res_value    <= r_m_meta.in_rng ? newv : '0;
            r_res_in_range <= r_m_meta.in_rng;
        end
    end

    assign o_en             = en;
    assign o_busy           = busy;
    assign o_res_valid      = r_res_valid;
    assign o_res_cell_value = r_res_value;
    assign o_res_in_range   = r_res_in_range;

endmodule

// ===== rtl/core/ogss_checker.sv =====
// ----------------------------------------------------------------------------
// ogss_checker
// Port-level checks for the grid store core, bound to the top level.
// ----------------------------------------------------------------------------
module ogss_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_req_valid,
    input logic                                 o_req_ready,
    input logic [ogss_pkg::CMD_W-1:0]           i_req_cmd,
    input logic signed [ogss_pkg::COORD_W-1:0]  i_req_coord_x,
    input logic signed [ogss_pkg::COORD_W-1:0]  i_req_coord_y,
    input logic [ogss_pkg::DATA_W-1:0]          i_req_data,
    input logic                                 o_res_valid,
    input logic                                 i_res_ready,
    input logic [ogss_pkg::DATA_W-1:0]          o_res_cell_value,
    input logic                                 o_res_in_range
);

    a_clear_blocks_req: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("request ready during clearing sweep");

    a_no_res_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res_in_range) |-> (o_res_cell_value == '0))
        else $error("out-of-range result with nonzero value");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_res_cell_value) && $stable(o_res_in_range)))
        else $error("stalled result changed");

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_ready) |=>
            (i_req_valid && $stable(i_req_cmd) && $stable(i_req_coord_x)
             && $stable(i_req_coord_y) && $stable(i_req_data)))
        else $error("waiting request changed");

endmodule

bind occupancy_grid_saturating_store_core ogss_checker u_ogss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req_valid),
    .o_req_ready      (o_req_ready),
    .i_req_cmd        (i_req_cmd),
    .i_req_coord_x    (i_req_coord_x),
    .i_req_coord_y    (i_req_coord_y),
    .i_req_data       (i_req_data),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_res_cell_value (o_res_cell_value),
    .o_res_in_range   (o_res_in_range)
);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the occupancy grid store core. A queue-fed driver
// and a result monitor apply random gaps and stalls on both channels. Each
// accepted request is run through a shadow copy of the grid and its
// saturation ceiling, and each result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF         = ogss_pkg::GRID_HALF_SPAN_DEF;
    localparam int SIDE         = ogss_pkg::GRID_SIDE_DEF;
    localparam int DEPTH        = SIDE * SIDE;
    localparam int CW           = ogss_pkg::COORD_W;
    localparam int DW           = ogss_pkg::DATA_W;
    localparam int PHASE_ITEMS  = 105;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [ogss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [ogss_pkg::CMD_W-1:0] cmd;
        logic signed [CW-1:0]       x;
        logic signed [CW-1:0]       y;
        logic [DW-1:0]              data;
    } t_grid_req;

    typedef struct {
        logic [DW-1:0] value;
        logic          hit;
    } t_cell_result;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [DW-1:0]              cfg_wdata = '0;
    logic                       req_valid = 1'b0;
    logic                       req_ready;
    logic [ogss_pkg::CMD_W-1:0] req_cmd   = ogss_pkg::CMD_GET;
    logic signed [CW-1:0]       req_x     = '0;
    logic signed [CW-1:0]       req_y     = '0;
    logic [DW-1:0]              req_data  = '0;
    logic                       res_valid;
    logic                       res_ready = 1'b0;
    logic [DW-1:0]              res_cell;
    logic                       res_in_range;

    t_grid_req    pending_reqs[$];
    t_cell_result expected_cells[$];
    t_grid_req    on_bus;

    logic [DW-1:0] grid_cells [DEPTH];
    logic [DW-1:0] sat_ceiling;

    int mismatch_count = 0;
    int send_gap       = 0;
    int take_stall     = 0;
    bit send_burst     = 1'b0;
    bit take_burst     = 1'b0;

    occupancy_grid_saturating_store_core #(
        .GRID_HALF_SPAN (HALF),
        .GRID_SIDE      (SIDE)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_req_valid      (req_valid),
        .o_req_ready      (req_ready),
        .i_req_cmd        (req_cmd),
        .i_req_coord_x    (req_x),
        .i_req_coord_y    (req_y),
        .i_req_data       (req_data),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res_cell_value (res_cell),
        .o_res_in_range   (res_in_range)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic t_cell_result apply_grid_request(input t_grid_req r);
        t_cell_result  res;
        int            xi;
        int            yi;
        int            addr;
        logic [DW-1:0] cur;
        logic [DW-1:0] sum;
        logic          rising;
        xi = int'(r.x);
        yi = int'(r.y);
        if (xi < -HALF || xi > HALF || yi < -HALF || yi > HALF) begin
            res.value = '0;
            res.hit   = 1'b0;
        end else begin
            addr = ((xi + HALF) * SIDE + (HALF - yi)) % DEPTH;
            cur  = grid_cells[addr];
            if (r.cmd == ogss_pkg::CMD_SET) begin
                cur = r.data;
            end else if (r.cmd == ogss_pkg::CMD_CHANGE) begin
                sum    = cur + r.data;
                rising = (r.data != '0) && !r.data[DW-1];
                if (rising) begin
                    if (cur > sum) sum = sat_ceiling;
                end else if (cur < sum) begin
                    sum = '0;
                end
                cur = sum;
            end
            grid_cells[addr] = cur;
            res.value = cur;
            res.hit   = 1'b1;
        end
        return res;
    endfunction

    task automatic queue_request(input logic [ogss_pkg::CMD_W-1:0] cmd, input int x,
                                 input int y, input logic [DW-1:0] data);
        t_grid_req r;
        r.cmd  = cmd;
        r.x    = CW'(x);
        r.y    = CW'(y);
        r.data = data;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_cells.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(posedge clk) begin : driver
        t_grid_req nxt;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || req_ready) begin
            if (req_valid) begin
                expected_cells.push_back(apply_grid_request(on_bus));
            end
            if (send_gap > 0) begin
                send_gap--;
                req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt      = pending_reqs.pop_front();
                on_bus   = nxt;
                req_cmd  <= nxt.cmd;
                req_x    <= nxt.x;
                req_y    <= nxt.y;
                req_data <= nxt.data;
                req_valid <= 1'b1;
                if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 13);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : monitor
        t_cell_result exp_res;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected result cell_value %h in_range %b",
                                              res_cell, res_in_range));
                end else begin
                    exp_res = expected_cells.pop_front();
                    if (res_cell !== exp_res.value)
                        report_mismatch($sformatf("cell_value got %h expected %h",
                                                  res_cell, exp_res.value));
                    if (res_in_range !== exp_res.hit)
                        report_mismatch($sformatf("in_range got %b expected %b",
                                                  res_in_range, exp_res.hit));
                end
                if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
                take_stall = take_burst ? 0 : $urandom_range(0, 13);
            end else if (take_stall > 0) begin
                take_stall--;
            end
            res_ready <= (take_stall == 0);
        end
    end

    initial begin : sequencer
        logic [DW-1:0]        ceilings [NUM_PHASES];
        logic signed [CW-1:0] hot_x [4];
        logic signed [CW-1:0] hot_y [4];
        t_grid_req            r;
        int                   sel;
        int                   pos;
        int                   mag;
        int                   h;

        ceilings = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFE, 16'h0000};
        ceilings[NUM_PHASES-1] = DW'($urandom);
        for (int i = 0; i < DEPTH; i++) grid_cells[i] = '0;
        sat_ceiling = ogss_pkg::SAT_CEIL_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_request(ogss_pkg::CMD_GET,     0,       0,       16'h1234);
        queue_request(ogss_pkg::CMD_SET,     HALF,    HALF,    16'hFFFF);
        queue_request(ogss_pkg::CMD_GET,     HALF,    HALF,    16'h0000);
        queue_request(ogss_pkg::CMD_CHANGE,  HALF,    HALF,    16'h0001);
        queue_request(ogss_pkg::CMD_SET,    -HALF,   -HALF,    16'h0000);
        queue_request(ogss_pkg::CMD_CHANGE, -HALF,   -HALF,    16'hFFFF);
        queue_request(ogss_pkg::CMD_SET,     0,       0,       16'h7FFF);
        queue_request(ogss_pkg::CMD_CHANGE,  0,       0,       16'h0000);
        queue_request(ogss_pkg::CMD_CHANGE,  0,       0,       16'h7FFF);
        queue_request(ogss_pkg::CMD_CHANGE,  0,       0,       16'h8000);
        queue_request(ogss_pkg::CMD_CHANGE,  0,       0,       16'h8000);
        queue_request(CMD_UNUSED,            0,       0,       16'hFFFF);
        queue_request(ogss_pkg::CMD_SET,     HALF+1,  0,       16'h1111);
        queue_request(ogss_pkg::CMD_GET,     0,      -HALF-1,  16'h0000);
        queue_request(ogss_pkg::CMD_CHANGE, -HALF-1,  0,       16'h0001);
        queue_request(ogss_pkg::CMD_SET,     2047,   -2048,    16'hFFFF);
        queue_request(ogss_pkg::CMD_GET,    -2048,    2047,    16'h0000);
        queue_request(ogss_pkg::CMD_SET,    -HALF,    HALF,    16'hAAAA);
        queue_request(ogss_pkg::CMD_GET,    -HALF,    HALF,    16'h5555);
        queue_request(ogss_pkg::CMD_SET,     HALF,   -HALF,    16'h5555);
        queue_request(ogss_pkg::CMD_CHANGE,  HALF,   -HALF,    16'hFFFF);
        queue_request(CMD_UNUSED,           -2048,   -2048,    16'hAAAA);
        queue_request(ogss_pkg::CMD_GET,    -HALF,    HALF,    16'h0000);
        queue_request(ogss_pkg::CMD_GET,     HALF,   -HALF,    16'hFFFF);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= ceilings[p];
            @(posedge clk);
            cfg_we    <= 1'b0;
            sat_ceiling = ceilings[p];
            @(negedge clk);

            for (int k = 0; k < 4; k++) begin
                pos = $urandom_range(0, 2 * HALF);
                hot_x[k] = CW'(pos - HALF);
                pos = $urandom_range(0, 2 * HALF);
                hot_y[k] = CW'(pos - HALF);
            end

            repeat (PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    h   = $urandom_range(0, 3);
                    r.x = hot_x[h];
                    r.y = hot_y[h];
                end else if (sel < 92) begin
                    pos = $urandom_range(0, 2 * HALF);
                    r.x = CW'(pos - HALF);
                    pos = $urandom_range(0, 2 * HALF);
                    r.y = CW'(pos - HALF);
                end else if (sel < 96) begin
                    r.x = CW'($urandom);
                    r.y = CW'($urandom);
                end else begin
                    mag = HALF + 1 + $urandom_range(0, 6);
                    if ($urandom_range(0, 1)) mag = -mag;
                    pos = $urandom_range(0, 2 * HALF);
                    if ($urandom_range(0, 1)) begin
                        r.x = CW'(mag);
                        r.y = CW'(pos - HALF);
                    end else begin
                        r.x = CW'(pos - HALF);
                        r.y = CW'(mag);
                    end
                end

                sel = $urandom_range(0, 19);
                if (sel < 5) begin
                    r.cmd = ogss_pkg::CMD_SET;
                    case ($urandom_range(0, 2))
                        0: begin
                            r.data = 16'hF000 | 16'($urandom_range(0, 16'h0FFF));
                        end
                        1: begin
                            r.data = DW'($urandom_range(0, 255));
                        end
                        default: begin
                            r.data = DW'($urandom);
                        end
                    endcase
                end else if (sel < 14) begin
                    r.cmd = ogss_pkg::CMD_CHANGE;
                    case ($urandom_range(0, 4))
                        0: begin
                            r.data = DW'($urandom_range(1, 255));
                        end
                        1: begin
                            r.data = ~16'($urandom_range(0, 254));
                        end
                        2: begin
                            r.data = DW'($urandom_range(16'h4000, 16'h7FFF));
                        end
                        3: begin
                            r.data = DW'($urandom_range(16'h8000, 16'hC000));
                        end
                        default: begin
                            r.data = DW'($urandom);
                        end
                    endcase
                end else begin
                    r.cmd  = (sel < 19) ? ogss_pkg::CMD_GET : CMD_UNUSED;
                    r.data = DW'($urandom);
                end
                pending_reqs.push_back(r);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_cells.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
        if (mismatch_count == 0)
            $display("occupancy_grid_saturating_store_core verification clean");
        else
            $display("occupancy_grid_saturating_store_core verification failed");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * 8);
        $display("occupancy_grid_saturating_store_core verification failed");
        $finish;
    end

endmodule
